### hdl/pbss_pkg.sv
// ----------------------------------------------------------------------------
// pbss_pkg
// Types, codes and helpers shared by the host power sequencer modules.
// ----------------------------------------------------------------------------
package pbss_pkg;

  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [2:0] {
    KIND_TICK      = 3'd0,
    KIND_REMOTE    = 3'd1,
    KIND_HEARTBEAT = 3'd2,
    KIND_CLEAR     = 3'd3,
    KIND_SET_STATE = 3'd4
  } pbss_kind_e;

  typedef enum logic [2:0] {
    PST_OFF      = 3'd0,
    PST_BOOTING  = 3'd1,
    PST_ACTIVE   = 3'd2,
    PST_SHUTTING = 3'd3,
    PST_SHUTDOWN = 3'd4
  } pbss_pstate_e;

  localparam logic [CfgIdxW-1:0] REG_PRESS_WINDOW = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_HOLD_OFF     = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_HB_TIMEOUT   = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_TICK_MS      = 8'd3;

  localparam logic [15:0] PRESS_WINDOW_RST = 16'd100;
  localparam logic [15:0] HOLD_OFF_RST     = 16'd2000;
  localparam logic [31:0] HB_TIMEOUT_RST   = 32'd3000;
  localparam logic [7:0]  TICK_MS_RST      = 8'd10;

  typedef struct packed {
    logic [2:0]  kind;
    logic        button_pushed;
    logic        host_on;
    logic [31:0] now_ms;
    logic [7:0]  state_code;
  } pbss_item_t;

  typedef struct packed {
    logic [2:0] host_state;
    logic       hold_power;
    logic       host_alive;
    logic       ev_shutdown_requested;
    logic       ev_powered_on;
    logic       ev_shutdown_initiated;
    logic       ev_shutdown_aborted;
    logic       accepted;
  } pbss_result_t;

  typedef struct packed {
    logic [15:0] press_window_ms;
    logic [15:0] hold_off_ms;
    logic [31:0] heartbeat_timeout_ms;
    logic [7:0]  tick_ms;
  } pbss_cfg_t;

  typedef struct packed {
    logic [2:0]  power_state;
    logic [7:0]  press_count;
    logic [15:0] press_timer;
    logic [15:0] hold_timer;
    logic        long_press_done;
    logic        prev_pushed;
    logic [31:0] heartbeat_time;
    logic        heartbeat_seen;
    logic        power_latch;
  } pbss_state_t;

  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [7:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {9'd0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

endpackage

### hdl/pbss_if.sv
// ----------------------------------------------------------------------------
// pbss_if
// Valid/ready channels for items, results and register writes.
// ----------------------------------------------------------------------------
interface pbss_item_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic        button_pushed;
  logic        host_on;
  logic [31:0] now_ms;
  logic [7:0]  state_code;
  modport source (output valid, kind, button_pushed, host_on, now_ms, state_code,
                  input ready);
  modport sink   (input valid, kind, button_pushed, host_on, now_ms, state_code,
                  output ready);
endinterface

interface pbss_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] host_state;
  logic       hold_power;
  logic       host_alive;
  logic       ev_shutdown_requested;
  logic       ev_powered_on;
  logic       ev_shutdown_initiated;
  logic       ev_shutdown_aborted;
  logic       accepted;
  modport source (output valid, host_state, hold_power, host_alive, ev_shutdown_requested,
                  ev_powered_on, ev_shutdown_initiated, ev_shutdown_aborted, accepted,
                  input ready);
  modport sink   (input valid, host_state, hold_power, host_alive, ev_shutdown_requested,
                  ev_powered_on, ev_shutdown_initiated, ev_shutdown_aborted, accepted,
                  output ready);
endinterface

interface pbss_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/pbss_cfg_regs.sv
// ----------------------------------------------------------------------------
// pbss_cfg_regs
// Register file for the window, hold, heartbeat timeout and tick length.
// ----------------------------------------------------------------------------
module pbss_cfg_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      wr_valid_i,
  output logic                      wr_ready_o,
  input  logic [pbss_pkg::CfgIdxW-1:0]  wr_index_i,
  input  logic [pbss_pkg::CfgDataW-1:0] wr_data_i,
  output pbss_pkg::pbss_cfg_t       cfg_o
);
  import pbss_pkg::*;

  pbss_cfg_t cfg_q;

  assign wr_ready_o = 1'b1;
  assign cfg_o      = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.press_window_ms      <= PRESS_WINDOW_RST;
      cfg_q.hold_off_ms          <= HOLD_OFF_RST;
      cfg_q.heartbeat_timeout_ms <= HB_TIMEOUT_RST;
      cfg_q.tick_ms              <= TICK_MS_RST;
    end else if (wr_valid_i) begin
      case (wr_index_i)
        REG_PRESS_WINDOW: cfg_q.press_window_ms      <= wr_data_i[15:0];
        REG_HOLD_OFF:     cfg_q.hold_off_ms          <= wr_data_i[15:0];
        REG_HB_TIMEOUT:   cfg_q.heartbeat_timeout_ms <= wr_data_i[31:0];
        REG_TICK_MS:      cfg_q.tick_ms              <= wr_data_i[7:0];
        default: ;
      endcase
    end
  end

endmodule

### hdl/pbss_step.sv
// ----------------------------------------------------------------------------
// pbss_step
// Next-state and result logic for one item against the current state.
// ----------------------------------------------------------------------------
module pbss_step (
  input  pbss_pkg::pbss_item_t   item_i,
  input  pbss_pkg::pbss_state_t  state_i,
  input  pbss_pkg::pbss_cfg_t    cfg_i,
  output pbss_pkg::pbss_state_t  state_o,
  output pbss_pkg::pbss_result_t result_o
);
  import pbss_pkg::*;

  logic [31:0] hb_age;
  logic        rise;
  logic        fall;

  assign hb_age = item_i.now_ms - state_i.heartbeat_time;
  assign rise   = item_i.button_pushed & ~state_i.prev_pushed;
  assign fall   = ~item_i.button_pushed & state_i.prev_pushed;

  always_comb begin
    pbss_state_t  s;
    pbss_result_t r;
    s = state_i;
    r = '0;
    case (item_i.kind)
      KIND_TICK: begin
        s.press_timer = sat_add16(s.press_timer, cfg_i.tick_ms);
        if (rise) begin
          if (s.press_count != 8'hFF) s.press_count = s.press_count + 8'd1;
          s.press_timer = '0;
        end
        if (item_i.button_pushed) begin
          s.hold_timer = sat_add16(s.hold_timer, cfg_i.tick_ms);
          if (!s.long_press_done && s.hold_timer >= cfg_i.hold_off_ms) begin
            if (!item_i.host_on) begin
              r.ev_shutdown_requested = 1'b1;
              s.power_state           = PST_SHUTDOWN;
            end else if (s.power_state != PST_SHUTTING) begin
              r.ev_shutdown_requested = 1'b1;
              s.power_state           = PST_SHUTTING;
            end
            s.long_press_done = 1'b1;
          end
        end else if (fall) begin
          s.hold_timer      = '0;
          s.long_press_done = 1'b0;
        end
        case (s.power_state)
          PST_OFF: begin
            if (item_i.host_on) begin
              s.power_state   = PST_ACTIVE;
              r.ev_powered_on = 1'b1;
            end
          end
          PST_BOOTING: begin
            if (!item_i.host_on) begin
              s.power_state = PST_OFF;
            end else begin
              s.power_state   = PST_ACTIVE;
              r.ev_powered_on = 1'b1;
            end
          end
          PST_ACTIVE: begin
            if (!item_i.host_on) begin
              s.power_state = PST_OFF;
            end else begin
              if (s.press_timer > cfg_i.press_window_ms && s.press_count != 8'd0) begin
                r.ev_shutdown_initiated = 1'b1;
                s.press_count           = '0;
                s.press_timer           = '0;
              end
              if (!item_i.button_pushed && s.hold_timer < cfg_i.hold_off_ms &&
                  s.hold_timer != 16'd0) begin
                r.ev_shutdown_aborted = 1'b1;
              end
            end
          end
          PST_SHUTTING: begin
            if (!item_i.host_on) s.power_state = PST_SHUTDOWN;
          end
          default: begin
            s.power_latch = 1'b0;
            if (!item_i.host_on) s.power_state = PST_OFF;
          end
        endcase
        s.prev_pushed = item_i.button_pushed;
      end
      KIND_REMOTE: begin
        if (!item_i.host_on) begin
          r.ev_shutdown_requested = 1'b1;
          s.power_state           = PST_SHUTDOWN;
        end else if (s.power_state != PST_SHUTTING && s.power_state != PST_SHUTDOWN) begin
          r.ev_shutdown_requested = 1'b1;
          s.power_state           = PST_SHUTTING;
        end
      end
      KIND_HEARTBEAT: begin
        s.heartbeat_time = item_i.now_ms;
        s.heartbeat_seen = 1'b1;
        if (item_i.host_on &&
            (s.power_state == PST_OFF || s.power_state == PST_BOOTING)) begin
          s.power_state   = PST_ACTIVE;
          r.ev_powered_on = 1'b1;
        end
      end
      KIND_CLEAR: begin
        if (s.power_state == PST_SHUTTING) begin
          s.power_state         = PST_ACTIVE;
          r.ev_shutdown_aborted = 1'b1;
          r.accepted            = 1'b1;
        end
      end
      KIND_SET_STATE: begin
        if (item_i.state_code <= 8'(PST_SHUTDOWN)) begin
          s.power_state = item_i.state_code[2:0];
          r.accepted    = 1'b1;
        end
      end
      default: ;
    endcase
    // heartbeat in this item stamps now, so its age is zero
    r.host_alive = (item_i.kind == KIND_HEARTBEAT) ||
                   (state_i.heartbeat_seen && hb_age <= cfg_i.heartbeat_timeout_ms);
    r.host_state = s.power_state;
    r.hold_power = s.power_latch;
    state_o      = s;
    result_o     = r;
  end

endmodule

### hdl/power_button_shutdown_sequencer.sv
// ----------------------------------------------------------------------------
// power_button_shutdown_sequencer
// Host power sequencer with button, heartbeat and remote shutdown handling.
// ----------------------------------------------------------------------------
// Every accepted item yields exactly one result beat. Items enter an input
// register, the step logic updates the power state from that register and
// loads the result register, so one item is taken per clock. Throughput drops
// only while the result register is held by a stalled sink. Register writes
// are always ready and take effect on the following item.
module power_button_shutdown_sequencer (
  input  logic           clk_i,
  input  logic           rst_ni,
  pbss_item_if.sink      in_i,
  pbss_result_if.source  out_o,
  pbss_cfg_if.sink       cfg_i
);
  import pbss_pkg::*;

  pbss_cfg_t    cfg;
  pbss_item_t   item_q;
  logic         item_valid_q;
  pbss_state_t  state_q;
  pbss_state_t  state_d;
  pbss_result_t res_d;
  pbss_result_t res_q;
  logic         res_valid_q;
  logic         advance;

  pbss_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_ready_o (cfg_i.ready),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  pbss_step u_step (
    .item_i   (item_q),
    .state_i  (state_q),
    .cfg_i    (cfg),
    .state_o  (state_d),
    .result_o (res_d)
  );

  assign advance  = item_valid_q & (~res_valid_q | out_o.ready);
  assign in_i.ready = ~item_valid_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      item_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.kind          <= in_i.kind;
      item_q.button_pushed <= in_i.button_pushed;
      item_q.host_on       <= in_i.host_on;
      item_q.now_ms        <= in_i.now_ms;
      item_q.state_code    <= in_i.state_code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.power_state     <= PST_OFF;
      state_q.press_count     <= '0;
      state_q.press_timer     <= '0;
      state_q.hold_timer      <= '0;
      state_q.long_press_done <= 1'b0;
      state_q.prev_pushed     <= 1'b0;
      state_q.heartbeat_time  <= '0;
      state_q.heartbeat_seen  <= 1'b0;
      state_q.power_latch     <= 1'b1;
      res_valid_q             <= 1'b0;
    end else begin
      if (advance) begin
        state_q     <= state_d;
        res_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) res_q <= res_d;
  end

  assign out_o.valid                 = res_valid_q;
  assign out_o.host_state            = res_q.host_state;
  assign out_o.hold_power            = res_q.hold_power;
  assign out_o.host_alive            = res_q.host_alive;
  assign out_o.ev_shutdown_requested = res_q.ev_shutdown_requested;
  assign out_o.ev_powered_on         = res_q.ev_powered_on;
  assign out_o.ev_shutdown_initiated = res_q.ev_shutdown_initiated;
  assign out_o.ev_shutdown_aborted   = res_q.ev_shutdown_aborted;
  assign out_o.accepted              = res_q.accepted;

endmodule

### hdl/pbss_checker.sv
// ----------------------------------------------------------------------------
// pbss_checker
// Port-level checks for the host power sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module pbss_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] host_state_i,
  input logic       hold_power_i,
  input logic       ev_powered_on_i,
  input logic       ev_shutdown_initiated_i,
  input logic       ev_shutdown_aborted_i
);
  import pbss_pkg::*;

  logic latch_cut_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_cut_q <= 1'b0;
    end else if (out_valid_i && out_ready_i && !hold_power_i) begin
      latch_cut_q <= 1'b1;
    end
  end

  // power latch never comes back once a beat showed it cut
  a_latch_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && latch_cut_q |-> !hold_power_i)
    else $error("power latch returned after cut");

  a_events_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (ev_powered_on_i || ev_shutdown_initiated_i || ev_shutdown_aborted_i)
    |-> host_state_i == PST_ACTIVE)
    else $error("event flag without active state");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(host_state_i) && $stable(hold_power_i))
    else $error("result beat changed while stalled");

endmodule

bind power_button_shutdown_sequencer pbss_checker u_pbss_checker (
  .clk_i                   (clk_i),
  .rst_ni                  (rst_ni),
  .out_valid_i             (out_o.valid),
  .out_ready_i             (out_o.ready),
  .host_state_i            (out_o.host_state),
  .hold_power_i            (out_o.hold_power),
  .ev_powered_on_i         (out_o.ev_powered_on),
  .ev_shutdown_initiated_i (out_o.ev_shutdown_initiated),
  .ev_shutdown_aborted_i   (out_o.ev_shutdown_aborted)
);

### verif/power_button_shutdown_sequencer_tb.sv
// ----------------------------------------------------------------------------
// power_button_shutdown_sequencer_tb
// Self-checking bench for the host power sequencer. A queue of pending items
// feeds a clocked driver. A clocked monitor steps a local model of the power
// machine, button timers, heartbeat and latch for every accepted beat and
// compares each result beat with the oldest prediction. The stimulus runs a
// short directed part and then several register settings: button bursts,
// long holds, power cycles, liveness probes, remote shutdowns, state writes
// and noise. Both channels idle and stall in random bursts.
// ----------------------------------------------------------------------------
module power_button_shutdown_sequencer_tb;
  import pbss_pkg::*;

  localparam int CycleLimit = 200000;
  localparam logic [2:0] KIND_RESERVED_FIRST = 3'd5;
  localparam logic [2:0] KIND_RESERVED_LAST  = 3'd7;

  typedef struct {
    pbss_pstate_e pstate;
    logic [7:0]   presses;
    logic [15:0]  press_ms;
    logic [15:0]  hold_acc;
    logic         hold_done;
    logic         was_pushed;
    logic         hb_seen;
    logic         latch;
    logic [31:0]  hb_stamp;
    logic [15:0]  window_ms;
    logic [15:0]  hold_off;
    logic [31:0]  hb_timeout;
    logic [7:0]   tick_len;
  } host_model_t;

  logic clk = 1'b0;
  logic rst_ni;

  pbss_item_if   item_ch ();
  pbss_result_if res_ch ();
  pbss_cfg_if    cfg_ch ();

  power_button_shutdown_sequencer dut (
    .clk_i  (clk),
    .rst_ni (rst_ni),
    .in_i   (item_ch),
    .out_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  always #4 clk = ~clk;

  pbss_item_t   pend_items[$];
  pbss_result_t status_expected[$];
  host_model_t  plan;
  host_model_t  live;
  pbss_item_t   next_item;
  pbss_item_t   mon_item;
  pbss_result_t mon_want;
  logic [31:0]  stamp;
  logic         item_taken = 1'b0;
  bit           calm = 1'b0;
  bit           cut_ok = 1'b0;
  int           planned;
  int           mismatches = 0;
  int           cycle_count = 0;
  int           send_gap = 0;
  int           send_smooth = 0;
  int           take_gap = 0;
  int           take_smooth = 0;

  function automatic host_model_t reset_model();
    host_model_t m;
    m.pstate     = PST_OFF;
    m.presses    = '0;
    m.press_ms   = '0;
    m.hold_acc   = '0;
    m.hold_done  = 1'b0;
    m.was_pushed = 1'b0;
    m.hb_seen    = 1'b0;
    m.latch      = 1'b1;
    m.hb_stamp   = '0;
    m.window_ms  = PRESS_WINDOW_RST;
    m.hold_off   = HOLD_OFF_RST;
    m.hb_timeout = HB_TIMEOUT_RST;
    m.tick_len   = TICK_MS_RST;
    return m;
  endfunction

  function automatic void apply_reg(inout host_model_t m, input logic [7:0] idx,
                                    input logic [31:0] val);
    case (idx)
      REG_PRESS_WINDOW: m.window_ms  = val[15:0];
      REG_HOLD_OFF:     m.hold_off   = val[15:0];
      REG_HB_TIMEOUT:   m.hb_timeout = val;
      REG_TICK_MS:      m.tick_len   = val[7:0];
      default: ;
    endcase
  endfunction

  function automatic logic [15:0] bump_ms(logic [15:0] t, logic [7:0] d);
    logic [16:0] s;
    s = {1'b0, t} + {9'd0, d};
    return (s > 17'h0FFFF) ? 16'hFFFF : s[15:0];
  endfunction

  function automatic pbss_result_t step_power(inout host_model_t m, input pbss_item_t it);
    pbss_result_t r;
    logic         rise;
    logic         fall;
    logic         push;
    logic         pwr;
    logic [31:0]  age;
    r    = '0;
    push = it.button_pushed;
    pwr  = it.host_on;
    case (it.kind)
      KIND_TICK: begin
        rise = push && !m.was_pushed;
        fall = !push && m.was_pushed;
        m.press_ms = bump_ms(m.press_ms, m.tick_len);
        if (rise) begin
          if (m.presses != 8'hFF) m.presses = m.presses + 8'd1;
          m.press_ms = '0;
        end
        if (push) begin
          m.hold_acc = bump_ms(m.hold_acc, m.tick_len);
          if (!m.hold_done && m.hold_acc >= m.hold_off) begin
            if (!pwr) begin
              r.ev_shutdown_requested = 1'b1;
              m.pstate = PST_SHUTDOWN;
            end else if (m.pstate != PST_SHUTTING) begin
              m.pstate = PST_SHUTTING;
              r.ev_shutdown_requested = 1'b1;
            end
            m.hold_done = 1'b1;
          end
        end else if (fall) begin
          m.hold_acc  = '0;
          m.hold_done = 1'b0;
        end
        case (m.pstate)
          PST_OFF: begin
            if (pwr) begin
              m.pstate = PST_ACTIVE;
              r.ev_powered_on = 1'b1;
            end
          end
          PST_BOOTING: begin
            if (!pwr) m.pstate = PST_OFF;
            else begin
              m.pstate = PST_ACTIVE;
              r.ev_powered_on = 1'b1;
            end
          end
          PST_ACTIVE: begin
            if (!pwr) m.pstate = PST_OFF;
            else begin
              if (m.press_ms > m.window_ms && m.presses != 8'd0) begin
                r.ev_shutdown_initiated = 1'b1;
                m.presses  = '0;
                m.press_ms = '0;
              end
              if (!push && m.hold_acc < m.hold_off && m.hold_acc != 16'd0)
                r.ev_shutdown_aborted = 1'b1;
            end
          end
          PST_SHUTTING: begin
            if (!pwr) m.pstate = PST_SHUTDOWN;
          end
          default: begin
            m.latch = 1'b0;
            if (!pwr) m.pstate = PST_OFF;
          end
        endcase
        m.was_pushed = push;
      end
      KIND_REMOTE: begin
        if (!pwr) begin
          r.ev_shutdown_requested = 1'b1;
          m.pstate = PST_SHUTDOWN;
        end else if (m.pstate != PST_SHUTTING && m.pstate != PST_SHUTDOWN) begin
          m.pstate = PST_SHUTTING;
          r.ev_shutdown_requested = 1'b1;
        end
      end
      KIND_HEARTBEAT: begin
        m.hb_stamp = it.now_ms;
        m.hb_seen  = 1'b1;
        if (pwr && (m.pstate == PST_OFF || m.pstate == PST_BOOTING)) begin
          m.pstate = PST_ACTIVE;
          r.ev_powered_on = 1'b1;
        end
      end
      KIND_CLEAR: begin
        if (m.pstate == PST_SHUTTING) begin
          m.pstate = PST_ACTIVE;
          r.ev_shutdown_aborted = 1'b1;
          r.accepted = 1'b1;
        end
      end
      KIND_SET_STATE: begin
        if (it.state_code <= 8'(PST_SHUTDOWN)) begin
          m.pstate = pbss_pstate_e'(it.state_code[2:0]);
          r.accepted = 1'b1;
        end
      end
      default: ;
    endcase
    age          = it.now_ms - m.hb_stamp;
    r.host_state = m.pstate;
    r.hold_power = m.latch;
    r.host_alive = m.hb_seen && (age <= m.hb_timeout);
    return r;
  endfunction

  function automatic pbss_item_t make_item(logic [2:0] k, logic btn, logic pwr,
                                           logic [31:0] now, logic [7:0] code);
    pbss_item_t it;
    it.kind          = k;
    it.button_pushed = btn;
    it.host_on       = pwr;
    it.now_ms        = now;
    it.state_code    = code;
    return it;
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  // Queue one item; swap latch-cutting items for a harmless state write until the end.
  task automatic put(pbss_item_t it);
    host_model_t  trial;
    trial = plan;
    void'(step_power(trial, it));
    if (!trial.latch && !cut_ok) begin
      it = make_item(KIND_SET_STATE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     $urandom, 8'($urandom_range(PST_OFF, PST_SHUTTING)));
      trial = plan;
      void'(step_power(trial, it));
    end
    plan = trial;
    pend_items.push_back(it);
    planned++;
  endtask

  task automatic tick(logic btn, logic pwr);
    stamp = stamp + plan.tick_len;
    if ($urandom_range(0, 15) == 0) stamp = stamp + $urandom_range(0, 5000);
    put(make_item(KIND_TICK, btn, pwr, stamp, 8'($urandom_range(0, 255))));
  endtask

  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    apply_reg(plan, idx, val);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic settle();
    do @(posedge clk);
    while (pend_items.size() != 0 || item_ch.valid || status_expected.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_mix(int n);
    int          j;
    int          idle;
    int          need;
    logic        pwr;
    logic [31:0] probe;
    planned = 0;
    while (planned < n) begin
      pwr = ($urandom_range(0, 7) != 0);
      case ($urandom_range(0, 7))
        0, 1: begin
          j = $urandom_range(1, 4);
          repeat (j) begin
            repeat ($urandom_range(1, 3)) tick(1'b1, pwr);
            repeat ($urandom_range(1, 2)) tick(1'b0, pwr);
          end
          idle = (plan.tick_len == 0) ? 3 : plan.window_ms / plan.tick_len + 2;
          if (idle > 30) idle = $urandom_range(2, 30);
          repeat (idle) tick(1'b0, pwr);
        end
        2: begin
          pwr  = ($urandom_range(0, 5) != 0);
          need = (plan.tick_len == 0) ? 4 : plan.hold_off / plan.tick_len + 1;
          if (need > 40 || $urandom_range(0, 3) == 0) need = $urandom_range(1, 40);
          repeat (need) tick(1'b1, pwr);
          tick(1'b0, pwr);
          if ($urandom_range(0, 1) == 1)
            put(make_item(KIND_CLEAR, 1'b0, pwr, stamp, 8'($urandom_range(0, 255))));
        end
        3: begin
          repeat ($urandom_range(1, 4)) tick(1'($urandom_range(0, 1)), 1'b0);
          if ($urandom_range(0, 1) == 1)
            put(make_item(KIND_SET_STATE, 1'b0, 1'b0, stamp, 8'(PST_BOOTING)));
          repeat ($urandom_range(1, 3)) tick(1'b0, 1'b1);
          put(make_item(KIND_HEARTBEAT, 1'b0, 1'b1, stamp, 8'($urandom_range(0, 255))));
        end
        4: begin
          if ($urandom_range(0, 3) == 0) stamp = $urandom;
          put(make_item(KIND_HEARTBEAT, 1'($urandom_range(0, 1)), pwr, stamp,
                        8'($urandom_range(0, 255))));
          probe = stamp + plan.hb_timeout + $urandom_range(0, 2) - 1;
          put(make_item(3'($urandom_range(KIND_TICK, KIND_RESERVED_LAST)), 1'b0, 1'b1, probe,
                        8'($urandom_range(0, 255))));
          tick(1'b0, 1'b1);
        end
        5: begin
          put(make_item(KIND_REMOTE, 1'($urandom_range(0, 1)), pwr, stamp,
                        8'($urandom_range(0, 255))));
          case ($urandom_range(0, 2))
            0: put(make_item(KIND_CLEAR, 1'b0, 1'b1, stamp, 8'($urandom_range(0, 255))));
            1: repeat ($urandom_range(1, 3)) tick(1'b0, 1'b0);
            default: put(make_item(KIND_SET_STATE, 1'b0, 1'b1, stamp,
                                   8'($urandom_range(0, 255))));
          endcase
        end
        6: begin
          put(make_item($urandom_range(0, 3) == 0 ?
                        3'($urandom_range(KIND_RESERVED_FIRST, KIND_RESERVED_LAST)) :
                        KIND_SET_STATE,
                        1'($urandom_range(0, 1)), pwr, $urandom,
                        8'($urandom_range(0, 255))));
        end
        default: begin
          put(make_item(3'($urandom_range(KIND_TICK, KIND_RESERVED_LAST)),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom,
                        8'($urandom_range(0, 255))));
        end
      endcase
    end
  endtask

  // Saturate the press counter, then both timers, then fire the short-press shutdown.
  task automatic press_storm();
    put(make_item(KIND_SET_STATE, 1'b0, 1'b1, $urandom, 8'(PST_ACTIVE)));
    tick(1'b0, 1'b1);
    repeat (255) begin
      tick(1'b1, 1'b1);
      tick(1'b0, 1'b1);
    end
    repeat (262) tick(1'b1, 1'b1);
    put(make_item(KIND_CLEAR, 1'b0, 1'b1, stamp, 8'($urandom_range(0, 255))));
    tick(1'b0, 1'b1);
    tick(1'b0, 1'b1);
  endtask

  task automatic directed_part();
    tick(1'b0, 1'b0);
    put(make_item(KIND_HEARTBEAT, 1'b0, 1'b1, 32'd0, 8'd0));
    put(make_item(KIND_TICK, 1'b0, 1'b1, 32'd3000, 8'd0));
    put(make_item(KIND_TICK, 1'b0, 1'b1, 32'd3001, 8'hFF));
    put(make_item(KIND_HEARTBEAT, 1'b1, 1'b1, 32'hFFFF_FFF0, 8'hFF));
    put(make_item(KIND_TICK, 1'b0, 1'b1, 32'd5, 8'd0));
    put(make_item(KIND_TICK, 1'b0, 1'b1, 32'hFFFF_FFFF, 8'd0));
    put(make_item(KIND_REMOTE, 1'b0, 1'b1, 32'd0, 8'd0));
    put(make_item(KIND_REMOTE, 1'b0, 1'b1, 32'd0, 8'd0));
    put(make_item(KIND_CLEAR, 1'b0, 1'b1, 32'd0, 8'd0));
    put(make_item(KIND_CLEAR, 1'b0, 1'b1, 32'd0, 8'd0));
    put(make_item(KIND_SET_STATE, 1'b0, 1'b1, 32'd0, 8'hFF));
    put(make_item(KIND_SET_STATE, 1'b0, 1'b1, 32'd0, 8'(PST_SHUTDOWN) + 8'd1));
    put(make_item(KIND_SET_STATE, 1'b0, 1'b1, 32'd0, 8'(PST_BOOTING)));
    put(make_item(KIND_TICK, 1'b0, 1'b1, 32'd10, 8'd0));
    put(make_item(KIND_SET_STATE, 1'b0, 1'b1, 32'd10, 8'(PST_BOOTING)));
    put(make_item(KIND_TICK, 1'b0, 1'b0, 32'd20, 8'd0));
    put(make_item(KIND_RESERVED_FIRST, 1'b0, 1'b0, 32'd0, 8'd0));
    put(make_item(KIND_RESERVED_LAST, 1'b1, 1'b1, 32'hFFFF_FFFF, 8'hFF));
    put(make_item(KIND_RESERVED_FIRST + 3'd1, 1'b1, 1'b0, 32'h5555_AAAA, 8'hA5));
    put(make_item(KIND_TICK, 1'b1, 1'b1, 32'd30, 8'd0));
    put(make_item(KIND_TICK, 1'b0, 1'b1, 32'd40, 8'd0));
    put(make_item(KIND_REMOTE, 1'b0, 1'b0, 32'd50, 8'd0));
    put(make_item(KIND_HEARTBEAT, 1'b0, 1'b1, 32'd60, 8'd0));
    put(make_item(KIND_SET_STATE, 1'b0, 1'b1, 32'd60, 8'(PST_ACTIVE)));
    stamp = 32'd60;
  endtask

  task automatic write_all(logic [15:0] window, logic [15:0] hold, logic [31:0] timeout,
                           logic [7:0] tick_len);
    write_reg(REG_PRESS_WINDOW, {16'd0, window});
    write_reg(REG_HOLD_OFF, {16'd0, hold});
    write_reg(REG_HB_TIMEOUT, timeout);
    write_reg(REG_TICK_MS, {24'd0, tick_len});
  endtask

  initial begin
    rst_ni                      = 1'b0;
    item_ch.valid               = 1'b0;
    item_ch.kind                = '0;
    item_ch.button_pushed       = 1'b0;
    item_ch.host_on             = 1'b0;
    item_ch.now_ms              = '0;
    item_ch.state_code          = '0;
    res_ch.ready                = 1'b0;
    cfg_ch.valid                = 1'b0;
    cfg_ch.index                = '0;
    cfg_ch.data                 = '0;
    plan                        = reset_model();
    live                        = reset_model();
    stamp                       = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    directed_part();
    settle();

    write_all(16'd30, 16'd50, 32'd200, 8'd10);
    random_mix(250);
    settle();

    write_all(16'd0, 16'd0, 32'd0, 8'd1);
    random_mix(200);
    settle();

    write_all(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
    random_mix(150);
    settle();

    write_all(16'hFFFE, 16'hFFFF, 32'd1000, 8'hFF);
    press_storm();
    settle();

    write_all(16'd20, 16'd20, 32'd5000, 8'd0);
    random_mix(40);
    settle();

    write_all(16'd40, 16'd100, 32'd3000, 8'd20);
    calm   = 1'b1;
    cut_ok = 1'b1;
    random_mix(200);
    put(make_item(KIND_SET_STATE, 1'b0, 1'b1, stamp, 8'(PST_SHUTDOWN)));
    tick(1'b0, 1'b1);
    tick(1'b0, 1'b0);
    put(make_item(KIND_HEARTBEAT, 1'b0, 1'b1, stamp, 8'd0));
    tick(1'b1, 1'b1);
    settle();

    if (mismatches == 0) $display("power_button_shutdown_sequencer_tb: done, clean");
    else $display("power_button_shutdown_sequencer_tb: done, errors");
    $finish;
  end

  // Drive item beats; hold each until taken.
  always @(negedge clk) begin
    if (rst_ni) begin
      if (!item_ch.valid || item_taken) begin
        if (send_gap > 0) begin
          send_gap--;
          item_ch.valid <= 1'b0;
        end else if (pend_items.size() == 0) begin
          item_ch.valid <= 1'b0;
        end else if (!calm && send_smooth == 0 && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 2);
          item_ch.valid <= 1'b0;
        end else begin
          next_item = pend_items.pop_front();
          item_ch.valid         <= 1'b1;
          item_ch.kind          <= next_item.kind;
          item_ch.button_pushed <= next_item.button_pushed;
          item_ch.host_on       <= next_item.host_on;
          item_ch.now_ms        <= next_item.now_ms;
          item_ch.state_code    <= next_item.state_code;
        end
        if (send_smooth > 0) send_smooth--;
        else if ($urandom_range(0, 49) == 0) send_smooth = $urandom_range(20, 60);
      end
    end
  end

  // Stall result beats in short bursts.
  always @(negedge clk) begin
    if (rst_ni) begin
      if (take_gap > 0) begin
        take_gap--;
        res_ch.ready <= 1'b0;
      end else if (!calm && take_smooth == 0 && $urandom_range(0, 5) == 0) begin
        take_gap = $urandom_range(0, 2);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
      if (take_smooth > 0) take_smooth--;
      else if ($urandom_range(0, 49) == 0) take_smooth = $urandom_range(20, 60);
    end
  end

  always @(posedge clk) begin
    if (rst_ni) begin
      item_taken <= item_ch.valid && item_ch.ready;
      if (cfg_ch.valid && cfg_ch.ready) apply_reg(live, cfg_ch.index, cfg_ch.data);
      if (res_ch.valid && res_ch.ready) begin
        if (status_expected.size() == 0) begin
          $error("result beat with no item pending");
          mismatches++;
        end else begin
          mon_want = status_expected.pop_front();
          check_field("host_state", 32'(mon_want.host_state), 32'(res_ch.host_state));
          check_field("hold_power", 32'(mon_want.hold_power), 32'(res_ch.hold_power));
          check_field("host_alive", 32'(mon_want.host_alive), 32'(res_ch.host_alive));
          check_field("ev_shutdown_requested", 32'(mon_want.ev_shutdown_requested),
                      32'(res_ch.ev_shutdown_requested));
          check_field("ev_powered_on", 32'(mon_want.ev_powered_on),
                      32'(res_ch.ev_powered_on));
          check_field("ev_shutdown_initiated", 32'(mon_want.ev_shutdown_initiated),
                      32'(res_ch.ev_shutdown_initiated));
          check_field("ev_shutdown_aborted", 32'(mon_want.ev_shutdown_aborted),
                      32'(res_ch.ev_shutdown_aborted));
          check_field("accepted", 32'(mon_want.accepted), 32'(res_ch.accepted));
        end
      end
      if (item_ch.valid && item_ch.ready) begin
        mon_item = make_item(item_ch.kind, item_ch.button_pushed, item_ch.host_on,
                             item_ch.now_ms, item_ch.state_code);
        status_expected.push_back(step_power(live, mon_item));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("power_button_shutdown_sequencer_tb: done, errors");
      $finish;
    end
  end

endmodule

### power_button_shutdown_sequencer.f
hdl/pbss_pkg.sv
hdl/pbss_if.sv
hdl/pbss_cfg_regs.sv
hdl/pbss_step.sv
hdl/power_button_shutdown_sequencer.sv
hdl/pbss_checker.sv
verif/power_button_shutdown_sequencer_tb.sv
